@@ design/sgfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgfd_pkg
// Shared constants, register codes, state type and control structs for the
// staggered-grid first-derivative block.
// ----------------------------------------------------------------------------
package sgfd_pkg;

  localparam int MAX_TAPS_DEF    = 6;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int NUM_COEF   = 6;
  localparam int COEF_W     = 18;
  localparam int TAPS_W     = 3;
  localparam int INV_W      = 24;
  localparam int OUT_W      = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  localparam logic [TAPS_W-1:0] TAPS_RESET = 3'd1;
  localparam logic [INV_W-1:0]  INV_RESET  = 24'd65536;

  typedef enum logic [CFG_ADDR_W-3:0] {
    REG_COEF_0 = 3'd0,
    REG_COEF_1 = 3'd1,
    REG_COEF_2 = 3'd2,
    REG_COEF_3 = 3'd3,
    REG_COEF_4 = 3'd4,
    REG_COEF_5 = 3'd5,
    REG_TAPS   = 3'd6,
    REG_INV    = 3'd7
  } sgfd_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ALIGN,
    ST_TAP,
    ST_SCL_LO,
    ST_SCL_HI,
    ST_SAT
  } sgfd_state_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic align;
    logic mac;
    logic scale_lo;
    logic scale_hi;
    logic load_out;
  } sgfd_cmd_t;

  typedef struct packed {
    logic produce;
    logic out_free;
  } sgfd_status_t;

endpackage
`default_nettype wire

@@ design/sgfd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgfd_if
// Valid/ready stream channels: samples in, derivatives out.
// ----------------------------------------------------------------------------
interface sgfd_in_if #(
  parameter int SAMPLE_BITS = sgfd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_in_line;

  modport source (output valid, output sample, output last_in_line, input ready);
  modport sink   (input valid, input sample, input last_in_line, output ready);
endinterface

interface sgfd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sgfd_pkg::OUT_W-1:0] derivative;
  logic                              last_of_line;

  modport source (output valid, output derivative, output last_of_line, input ready);
  modport sink   (input valid, input derivative, input last_of_line, output ready);
endinterface
`default_nettype wire

@@ design/sgfd_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgfd_regs
// APB-style configuration registers: stencil coefficients, tap count and
// reciprocal grid spacing.
// ----------------------------------------------------------------------------
module sgfd_regs (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [sgfd_pkg::CFG_ADDR_W-1:0]        paddr,
  input  wire logic [sgfd_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic      [sgfd_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                        pready,
  output logic signed [sgfd_pkg::COEF_W-1:0]          coef [sgfd_pkg::NUM_COEF],
  output logic      [sgfd_pkg::TAPS_W-1:0]            taps,
  output logic      [sgfd_pkg::INV_W-1:0]             inv
);

  logic signed [sgfd_pkg::COEF_W-1:0] coef_r   [sgfd_pkg::NUM_COEF];
  logic signed [sgfd_pkg::COEF_W-1:0] coef_nxt [sgfd_pkg::NUM_COEF];
  logic [sgfd_pkg::TAPS_W-1:0]        taps_r, taps_nxt;
  logic [sgfd_pkg::INV_W-1:0]         inv_r, inv_nxt;
  logic                               wr;
  sgfd_pkg::sgfd_reg_t                idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = sgfd_pkg::sgfd_reg_t'(paddr[sgfd_pkg::CFG_ADDR_W-1:2]);

  always_comb begin
    coef_nxt = coef_r;
    taps_nxt = taps_r;
    inv_nxt  = inv_r;
    if (wr) begin
      unique case (idx)
        sgfd_pkg::REG_COEF_0: coef_nxt[0] = signed'(pwdata[sgfd_pkg::COEF_W-1:0]);
        sgfd_pkg::REG_COEF_1: coef_nxt[1] = signed'(pwdata[sgfd_pkg::COEF_W-1:0]);
        sgfd_pkg::REG_COEF_2: coef_nxt[2] = signed'(pwdata[sgfd_pkg::COEF_W-1:0]);
        sgfd_pkg::REG_COEF_3: coef_nxt[3] = signed'(pwdata[sgfd_pkg::COEF_W-1:0]);
        sgfd_pkg::REG_COEF_4: coef_nxt[4] = signed'(pwdata[sgfd_pkg::COEF_W-1:0]);
        sgfd_pkg::REG_COEF_5: coef_nxt[5] = signed'(pwdata[sgfd_pkg::COEF_W-1:0]);
        sgfd_pkg::REG_TAPS:   taps_nxt    = pwdata[sgfd_pkg::TAPS_W-1:0];
        sgfd_pkg::REG_INV:    inv_nxt     = pwdata[sgfd_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sgfd_pkg::NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
      taps_r <= sgfd_pkg::TAPS_RESET;
      inv_r  <= sgfd_pkg::INV_RESET;
    end else begin
      coef_r <= coef_nxt;
      taps_r <= taps_nxt;
      inv_r  <= inv_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      sgfd_pkg::REG_COEF_0: prdata = sgfd_pkg::CFG_DATA_W'(coef_r[0]);
      sgfd_pkg::REG_COEF_1: prdata = sgfd_pkg::CFG_DATA_W'(coef_r[1]);
      sgfd_pkg::REG_COEF_2: prdata = sgfd_pkg::CFG_DATA_W'(coef_r[2]);
      sgfd_pkg::REG_COEF_3: prdata = sgfd_pkg::CFG_DATA_W'(coef_r[3]);
      sgfd_pkg::REG_COEF_4: prdata = sgfd_pkg::CFG_DATA_W'(coef_r[4]);
      sgfd_pkg::REG_COEF_5: prdata = sgfd_pkg::CFG_DATA_W'(coef_r[5]);
      sgfd_pkg::REG_TAPS:   prdata = sgfd_pkg::CFG_DATA_W'(taps_r);
      sgfd_pkg::REG_INV:    prdata = sgfd_pkg::CFG_DATA_W'(inv_r);
      default:              prdata = '0;
    endcase
  end

  assign coef = coef_r;
  assign taps = taps_r;
  assign inv  = inv_r;

endmodule
`default_nettype wire

@@ design/sgfd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgfd_ctrl
// Sequencer: takes an item, aligns the stencil window, steps the shared
// multiply-accumulate over the taps, scales and hands the result on.
// ----------------------------------------------------------------------------
module sgfd_ctrl #(
  parameter int MAX_TAPS = sgfd_pkg::MAX_TAPS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [$clog2(MAX_TAPS+1)-1:0] k,
  input  wire sgfd_pkg::sgfd_status_t        status,
  output sgfd_pkg::sgfd_cmd_t                cmd,
  output logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] tap_idx
);

  localparam int CNT_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  sgfd_pkg::sgfd_state_t state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sgfd_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      sgfd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.produce) begin
            state_nxt = sgfd_pkg::ST_LOAD;
          end
        end
      end
      sgfd_pkg::ST_LOAD: begin
        cmd.load = 1'b1;
        if (int'(k) < MAX_TAPS) begin
          state_nxt = sgfd_pkg::ST_ALIGN;
          cnt_nxt   = CNT_W'(MAX_TAPS - int'(k) - 1);
        end else begin
          state_nxt = sgfd_pkg::ST_TAP;
          cnt_nxt   = CNT_W'(int'(k) - 1);
        end
      end
      sgfd_pkg::ST_ALIGN: begin
        // slide the far half down two places per step until it sits on 2K-1
        cmd.align = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = sgfd_pkg::ST_TAP;
          cnt_nxt   = CNT_W'(int'(k) - 1);
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      sgfd_pkg::ST_TAP: begin
        cmd.mac = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = sgfd_pkg::ST_SCL_LO;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      sgfd_pkg::ST_SCL_LO: begin
        cmd.scale_lo = 1'b1;
        state_nxt    = sgfd_pkg::ST_SCL_HI;
      end
      sgfd_pkg::ST_SCL_HI: begin
        cmd.scale_hi = 1'b1;
        state_nxt    = sgfd_pkg::ST_SAT;
      end
      sgfd_pkg::ST_SAT: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = sgfd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sgfd_pkg::ST_IDLE;
    endcase
  end

  // taps run from the outermost inwards, so the count is the tap number
  assign tap_idx = cnt_r;

`ifndef ASSERT_OFF
  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sgfd_pkg::ST_TAP |-> int'(cnt_r) < int'(k))
    else $error("tap count beyond active taps");

  a_tap_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sgfd_pkg::ST_TAP && cnt_r == '0) |=> state_r == sgfd_pkg::ST_SCL_LO)
    else $error("tap loop did not finish on last tap");

  a_sat_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sgfd_pkg::ST_SAT && !status.out_free) |=> state_r == sgfd_pkg::ST_SAT)
    else $error("result dropped while output register busy");
`endif

endmodule
`default_nettype wire

@@ design/sgfd_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgfd_dp
// Datapath: sample window and fill count, aligned work copies, one shared
// multiply-accumulate, two-step scaling multiply, saturation and output
// register.
// ----------------------------------------------------------------------------
module sgfd_dp #(
  parameter int MAX_TAPS    = sgfd_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = sgfd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire sgfd_pkg::sgfd_cmd_t                    cmd,
  input  wire logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] tap_idx,
  input  wire logic signed [sgfd_pkg::COEF_W-1:0]     coef [sgfd_pkg::NUM_COEF],
  input  wire logic [sgfd_pkg::TAPS_W-1:0]            taps,
  input  wire logic [sgfd_pkg::INV_W-1:0]             inv,
  input  wire logic signed [SAMPLE_BITS-1:0]          in_sample,
  input  wire logic                                   in_last,
  output logic [$clog2(MAX_TAPS+1)-1:0]               k,
  output sgfd_pkg::sgfd_status_t                      status,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [sgfd_pkg::OUT_W-1:0]           out_derivative,
  output logic                                        out_last
);

  localparam int WIN    = 2 * MAX_TAPS;
  localparam int FILL_W = $clog2(WIN + 1);
  localparam int K_W    = $clog2(MAX_TAPS + 1);
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = sgfd_pkg::COEF_W + DIFF_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
  localparam int HI_W   = ACC_W - sgfd_pkg::INV_W;
  localparam int P_W    = ACC_W + sgfd_pkg::INV_W + 1;
  localparam int Q_W    = P_W - sgfd_pkg::OUT_W;
  localparam int SAT_W  = (Q_W > sgfd_pkg::OUT_W + 1) ? Q_W : sgfd_pkg::OUT_W + 1;

  localparam logic signed [SAT_W-1:0] POS_LIM =
    {{(SAT_W - sgfd_pkg::OUT_W){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [SAT_W-1:0] NEG_LIM =
    {{(SAT_W - sgfd_pkg::OUT_W){1'b1}}, 32'h8000_0000};

  logic signed [SAMPLE_BITS-1:0] win_r [WIN];
  logic signed [SAMPLE_BITS-1:0] a_r   [WIN];
  logic signed [SAMPLE_BITS-1:0] b_r   [WIN];
  logic [FILL_W-1:0]             fill_r;
  logic [FILL_W-1:0]             fill_inc;
  logic                          last_r;
  logic                          produce;

  logic signed [sgfd_pkg::COEF_W-1:0] c_sel;
  logic signed [DIFF_W-1:0]           diff;
  logic signed [PROD_W-1:0]           prod;
  logic signed [ACC_W-1:0]            acc_r;

  logic [sgfd_pkg::INV_W-1:0]         s_lo;
  logic [2*sgfd_pkg::INV_W-1:0]       p_lo_r;
  logic signed [HI_W-1:0]             s_hi;
  logic signed [sgfd_pkg::INV_W:0]    inv_s;
  logic signed [ACC_W:0]              p_hi;
  logic signed [P_W-1:0]              hi_ext;
  logic signed [P_W-1:0]              lo_ext;
  logic signed [P_W-1:0]              sum_r;

  logic signed [Q_W-1:0]              q;
  logic signed [SAT_W-1:0]            q_ext;
  logic signed [sgfd_pkg::OUT_W-1:0]  res;

  logic                               out_valid_r;
  logic signed [sgfd_pkg::OUT_W-1:0]  out_deriv_r;
  logic                               out_last_r;

  // active taps: zero acts as one, anything above MAX_TAPS acts as the maximum
  always_comb begin
    int t;
    t = int'(taps);
    if (t < 1) t = 1;
    if (t > MAX_TAPS) t = MAX_TAPS;
    k = K_W'(t);
  end

  assign fill_inc = (int'(fill_r) < WIN) ? fill_r + 1'b1 : fill_r;
  assign produce  = int'(fill_inc) >= 2 * int'(k);

  assign status.produce  = produce;
  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.accept) begin
      fill_r <= in_last ? '0 : fill_inc;
    end
  end

  // newest sample at index 0
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      win_r[0] <= in_sample;
      for (int j = 1; j < WIN; j++) begin
        win_r[j] <= win_r[j-1];
      end
      last_r <= in_last;
    end
  end

  always_comb begin
    c_sel = '0;
    for (int i = 0; i < sgfd_pkg::NUM_COEF; i++) begin
      if (int'(tap_idx) == i) c_sel = coef[i];
    end
  end

  assign diff = DIFF_W'(a_r[0]) - DIFF_W'(b_r[0]);
  assign prod = c_sel * diff;

  // a_r walks up from the newest sample, b_r walks down from sample 2K-1
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int j = 0; j < WIN; j++) begin
        a_r[j] <= win_r[j];
        b_r[j] <= win_r[WIN-1-j];
      end
      acc_r <= '0;
    end else if (cmd.align) begin
      for (int j = 0; j < WIN; j++) begin
        if (j < WIN - 2) b_r[j] <= b_r[(j + 2) % WIN];
        else             b_r[j] <= '0;
      end
    end else if (cmd.mac) begin
      for (int j = 0; j < WIN; j++) begin
        if (j < WIN - 1) begin
          a_r[j] <= a_r[(j + 1) % WIN];
          b_r[j] <= b_r[(j + 1) % WIN];
        end else begin
          a_r[j] <= '0;
          b_r[j] <= '0;
        end
      end
      acc_r <= acc_r + ACC_W'(prod);
    end
  end

  // scale in two partial products: low INV_W bits unsigned, the rest signed
  assign s_lo   = acc_r[sgfd_pkg::INV_W-1:0];
  assign s_hi   = signed'(acc_r[ACC_W-1:sgfd_pkg::INV_W]);
  assign inv_s  = signed'({1'b0, inv});
  assign p_hi   = s_hi * inv_s;
  assign hi_ext = P_W'(p_hi) <<< sgfd_pkg::INV_W;
  assign lo_ext = signed'(P_W'(p_lo_r));

  always_ff @(posedge clk) begin
    if (cmd.scale_lo) begin
      p_lo_r <= s_lo * inv;
    end
    if (cmd.scale_hi) begin
      sum_r <= hi_ext + lo_ext;
    end
  end

  // drop 32 fraction bits (floor), then clamp to 32 bits
  assign q     = signed'(sum_r[P_W-1:sgfd_pkg::OUT_W]);
  assign q_ext = SAT_W'(q);

  always_comb begin
    if (q_ext > POS_LIM)      res = 32'sh7FFF_FFFF;
    else if (q_ext < NEG_LIM) res = 32'sh8000_0000;
    else                      res = q_ext[sgfd_pkg::OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_deriv_r <= res;
      out_last_r  <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_derivative = out_deriv_r;
  assign out_last       = out_last_r;

`ifndef ASSERT_OFF
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_out))
    else $error("output valid raised without a result load");

  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && in_last) |=> fill_r == '0)
    else $error("fill count not cleared at line end");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=>
      (out_valid_r && $stable(out_deriv_r) && $stable(out_last_r)))
    else $error("waiting result changed before it was taken");
`endif

endmodule
`default_nettype wire

@@ design/staggered_grid_fd_derivative.sv @@
// ----------------------------------------------------------------------------
// staggered_grid_fd_derivative
// An item that gives no result is taken while the sequencer stays idle; in_ready
// stays high, so such items can follow back to back.
// An item that gives a result passes the load, the window align (when K is below
// MAX_TAPS), the K-step shared multiply-accumulate, the two-step scaling multiply
// and the output load; output valid is registered from that load. in_ready stays
// low until the sequencer is back in idle, so no item is taken meanwhile.
// A stalled output register holds the sequencer until the result is taken.
// Synchronous active-low reset clears control, fill count, config and out_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module staggered_grid_fd_derivative #(
  parameter int MAX_TAPS    = sgfd_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = sgfd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  sgfd_in_if.sink                              in_ch,
  sgfd_out_if.source                           out_ch,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [sgfd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [sgfd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [sgfd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int K_W   = $clog2(MAX_TAPS + 1);
  localparam int CNT_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  logic signed [sgfd_pkg::COEF_W-1:0] coef [sgfd_pkg::NUM_COEF];
  logic [sgfd_pkg::TAPS_W-1:0]        taps;
  logic [sgfd_pkg::INV_W-1:0]         inv;
  logic [K_W-1:0]                     k;
  logic [CNT_W-1:0]                   tap_idx;
  logic                               in_ready;
  sgfd_pkg::sgfd_cmd_t                cmd;
  sgfd_pkg::sgfd_status_t             status;

  assign in_ch.ready = in_ready;

  sgfd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .coef    (coef),
    .taps    (taps),
    .inv     (inv)
  );

  sgfd_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .k        (k),
    .status   (status),
    .cmd      (cmd),
    .tap_idx  (tap_idx)
  );

  sgfd_dp #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .tap_idx        (tap_idx),
    .coef           (coef),
    .taps           (taps),
    .inv            (inv),
    .in_sample      (in_ch.sample),
    .in_last        (in_ch.last_in_line),
    .k              (k),
    .status         (status),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_derivative (out_ch.derivative),
    .out_last       (out_ch.last_of_line)
  );

endmodule
`default_nettype wire

@@ test/staggered_grid_fd_derivative_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staggered_grid_fd_derivative_tb
// Streams lines of samples through the staggered-grid derivative block and
// checks every derivative against a predictor in this bench that mirrors
// the stencil window, the fill count and the scaling. The coefficients, tap
// count and reciprocal spacing go through the APB port between phases. The
// sender idles between bursts and the receiver stalls at random or on a pattern.
// ----------------------------------------------------------------------------
module staggered_grid_fd_derivative_tb;
  import sgfd_pkg::*;

  localparam int WIN_DEPTH    = 2 * MAX_TAPS_DEF;
  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT  = 400000;

  localparam int FILL_RANDOM  = 0;
  localparam int FILL_EXTREME = 1;

  localparam int RX_OPEN    = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;

  typedef struct {
    logic signed [SAMPLE_BITS_DEF-1:0] value;
    logic                              last;
  } sample_item_t;

  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    last;
  } deriv_item_t;

  logic clk;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  sgfd_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) in_ch ();
  sgfd_out_if out_ch ();

  staggered_grid_fd_derivative #(
    .MAX_TAPS    (MAX_TAPS_DEF),
    .SAMPLE_BITS (SAMPLE_BITS_DEF)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predictor state and register copies
  logic signed [COEF_W-1:0]          coef_r [NUM_COEF];
  logic [TAPS_W-1:0]                 taps_r;
  logic [INV_W-1:0]                  inv_r;
  logic signed [SAMPLE_BITS_DEF-1:0] stencil_win [WIN_DEPTH];
  int                                fill_cnt;

  sample_item_t sample_q [$];
  deriv_item_t  deriv_q [$];
  int           errors = 0;
  bit           in_taken = 1'b0;

  int burst_left = 0;
  int gap_left   = 0;
  int rdy_left   = 0;
  int rdy_mode   = RX_OPEN;
  logic [7:0] rdy_pat = 8'hFF;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int eff_taps(input logic [TAPS_W-1:0] t);
    if (t == 0) return 1;
    if (t > MAX_TAPS_DEF) return MAX_TAPS_DEF;
    return int'(t);
  endfunction

  // shift one sample into the window and queue the derivative it yields
  task automatic advance_stencil(input logic signed [SAMPLE_BITS_DEF-1:0] smp,
                                 input logic last);
    longint             acc;
    logic signed [95:0] a96;
    logic signed [95:0] b96;
    logic signed [95:0] q;
    int                 k;
    deriv_item_t        e;
    for (int j = WIN_DEPTH - 1; j > 0; j--) stencil_win[j] = stencil_win[j-1];
    stencil_win[0] = smp;
    if (fill_cnt < WIN_DEPTH) fill_cnt++;
    k = eff_taps(taps_r);
    if (fill_cnt >= 2 * k) begin
      acc = 0;
      for (int m = 0; m < k; m++) begin
        acc += longint'(coef_r[m]) *
               (longint'(stencil_win[k-1-m]) - longint'(stencil_win[k+m]));
      end
      a96 = 96'(acc);
      b96 = $signed({72'd0, inv_r});
      // arithmetic shift floors toward minus infinity
      q = (a96 * b96) >>> 32;
      if (q > 96'sd2147483647) q = 96'sd2147483647;
      else if (q < -96'sd2147483648) q = -96'sd2147483648;
      e.value = q[OUT_W-1:0];
      e.last  = last;
      deriv_q.push_back(e);
    end
    if (last) fill_cnt = 0;
  endtask

  // sender: bursts of items with random gaps, hold until accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_taken)) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left = gap_left - 1;
      end else if (sample_q.size() > 0) begin
        in_ch.valid        <= 1'b1;
        in_ch.sample       <= sample_q[0].value;
        in_ch.last_in_line <= sample_q[0].last;
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: open, random or patterned stalls; mode and pattern are redrawn when a run ends
  always @(negedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(RX_OPEN, RX_PATTERN);
      rdy_pat  = 8'($urandom());
      rdy_left = $urandom_range(20, 80);
    end else begin
      rdy_left = rdy_left - 1;
    end
    case (rdy_mode)
      RX_OPEN:   out_ch.ready <= 1'b1;
      RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default:   out_ch.ready <= rdy_pat[rdy_left % 8];
    endcase
  end

  // monitor: predict on accepted samples, check accepted derivatives
  always @(posedge clk) begin
    deriv_item_t e;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        void'(sample_q.pop_front());
        advance_stencil(in_ch.sample, in_ch.last_in_line);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (deriv_q.size() == 0) begin
          $display("%0t: unexpected item derivative=%0d last=%0b", $time,
                   out_ch.derivative, out_ch.last_of_line);
          errors++;
        end else begin
          e = deriv_q.pop_front();
          if (out_ch.derivative !== e.value) begin
            $display("%0t: derivative expected %0d actual %0d", $time,
                     e.value, out_ch.derivative);
            errors++;
          end
          if (out_ch.last_of_line !== e.last) begin
            $display("%0t: last_of_line expected %0b actual %0b", $time,
                     e.last, out_ch.last_of_line);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(input sgfd_reg_t r, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (r)
      REG_TAPS: taps_r = val[TAPS_W-1:0];
      REG_INV:  inv_r  = val[INV_W-1:0];
      default:  coef_r[int'(r)] = val[COEF_W-1:0];
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] sext_coef(input logic [COEF_W-1:0] v);
    return {{(CFG_DATA_W-COEF_W){v[COEF_W-1]}}, v};
  endfunction

  function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample(input int fill, input int idx);
    logic [31:0] r;
    r = $urandom();
    if (fill == FILL_EXTREME) return idx[0] ? 24'h800000 : 24'h7FFFFF;
    case ($urandom_range(0, 9))
      0:       return r[0] ? 24'h7FFFFF : 24'h800000;
      1, 2, 3: return 24'($urandom_range(0, 4095)) - 24'd2048;
      default: return r[SAMPLE_BITS_DEF-1:0];
    endcase
  endfunction

  task automatic push_line(input int len, input bit mark_end, input int fill);
    sample_item_t s;
    for (int i = 0; i < len; i++) begin
      s.value = pick_sample(fill, i);
      s.last  = mark_end && (i == len - 1);
      sample_q.push_back(s);
    end
  endtask

  // drain: every item taken, every derivative out, then the pipeline settles
  task automatic settle();
    while (sample_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (deriv_q.size() != 0) @(posedge clk);
    repeat (MAX_TAPS_DEF + 8) @(posedge clk);
  endtask

  task automatic randomise_setup();
    logic [31:0] r;
    logic [COEF_W-1:0] cv;
    for (int i = 0; i < NUM_COEF; i++) begin
      r = $urandom();
      case ($urandom_range(0, 7))
        0:       cv = 18'h1FFFF;
        1:       cv = 18'h20000;
        2, 3:    cv = 18'($urandom_range(0, 8191)) - 18'd4096;
        default: cv = r[COEF_W-1:0];
      endcase
      write_reg(sgfd_reg_t'(i), sext_coef(cv));
    end
    write_reg(REG_TAPS, 32'($urandom_range(0, 7)));
    r = $urandom();
    case ($urandom_range(0, 7))
      0:       write_reg(REG_INV, 32'hFFFFFF);
      1:       write_reg(REG_INV, 32'd0);
      2:       write_reg(REG_INV, 32'(INV_RESET));
      3:       write_reg(REG_INV, {8'd0, r[INV_W-1:0]});
      default: write_reg(REG_INV, 32'($urandom_range(1, 1 << 18)));
    endcase
  endtask

  initial begin
    int total;
    int plen;
    int n;
    int len;
    int k;
    bit mark;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.sample       = '0;
    in_ch.last_in_line = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    for (int i = 0; i < NUM_COEF; i++) coef_r[i] = '0;
    taps_r = TAPS_RESET;
    inv_r  = INV_RESET;
    for (int i = 0; i < WIN_DEPTH; i++) stencil_win[i] = '0;
    fill_cnt = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: zero coefficients, one tap; a three-sample line, then a one-sample line
    push_line(3, 1'b1, FILL_EXTREME);
    push_line(1, 1'b1, FILL_RANDOM);
    settle();

    // full-scale coefficients but the last (-1), widest stencil, largest spacing factor
    write_reg(REG_COEF_0, sext_coef(18'h1FFFF));
    write_reg(REG_COEF_1, sext_coef(18'h20000));
    write_reg(REG_COEF_2, sext_coef(18'h1FFFF));
    write_reg(REG_COEF_3, sext_coef(18'h20000));
    write_reg(REG_COEF_4, sext_coef(18'h1FFFF));
    write_reg(REG_COEF_5, sext_coef(18'h3FFFF));
    write_reg(REG_TAPS, 32'd6);
    write_reg(REG_INV, 32'hFFFFFF);
    push_line(13, 1'b1, FILL_EXTREME);
    // leave this line open across the tap change below
    push_line(3, 1'b0, FILL_EXTREME);
    settle();

    write_reg(REG_TAPS, 32'd0);
    write_reg(REG_INV, 32'd0);
    push_line(2, 1'b1, FILL_RANDOM);
    settle();

    // random phases; the last line of a phase may run on into the next one
    total = 0;
    while (total < RANDOM_ITEMS) begin
      randomise_setup();
      plen = $urandom_range(60, 160);
      n = 0;
      while (n < plen) begin
        k = eff_taps(taps_r);
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(1, 2 * k - 1);
          1:       len = $urandom_range(2 * k + 25, 2 * k + 60);
          default: len = $urandom_range(2 * k, 2 * k + 24);
        endcase
        mark = 1'b1;
        if (n + len > plen) begin
          len  = plen - n;
          mark = ($urandom_range(0, 2) == 0);
        end
        push_line(len, mark, FILL_RANDOM);
        n += len;
      end
      total += plen;
      settle();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
